// File: rtl/efla_pkg.sv
package efla_pkg;

  // fixed layout of the heap
  localparam int unsigned MIN_BLOCK_BYTES = 24;
  localparam logic [31:0] ROOT_BP = 32'd16;
  localparam logic [31:0] FIRST_BP = 32'd40;
  localparam logic [31:0] INIT_TOP = 32'd28;

  // opcodes and result status codes
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // base of a heap access
  typedef enum logic [3:0] {
    B_ROOT, B_BP, B_RD, B_P, B_N, B_FIRST, B_R, B_PRV, B_NXT, B_TAIL, B_ADDR
  } base_sel_t;

  // offset added to the base
  typedef enum logic [2:0] {
    O_HDR, O_NEXT, O_PREV, O_PFTR, O_ZERO, O_WHOLE, O_ASIZE, O_REST
  } off_sel_t;

  // data written to the heap
  typedef enum logic [3:0] {
    W_ZERO, W_WHOLE, W_WHOLE_A, W_ASIZE_A, W_REST, W_RD, W_ROOT, W_BP, W_R, W_N, W_P
  } wdata_sel_t;

  // register updates in the datapath
  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_DECODE, OP_LD_HEAD, OP_LD_NEXT, OP_LD_WHOLE, OP_CALC_EXT,
    OP_GROW_SET, OP_LD_FIRST, OP_REST, OP_LD_P, OP_LD_N, OP_FREE_SET, OP_LD_PRVNXT,
    OP_LD_PREVF, OP_LD_NEXTF, OP_TAIL_N, OP_TAIL_P, OP_ADD_N, OP_ADD_P, OP_MV_PRV,
    OP_RES_OK, OP_RES_ZERO, OP_RES_FULL, OP_RES_NONE
  } dp_op_t;

  typedef struct packed {
    logic       mem_rd;
    logic       mem_wr;
    base_sel_t  base;
    off_sel_t   off;
    wdata_sel_t wsel;
    dp_op_t     op;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic req_zero;
    logic addr_ok;
    logic rd_zero;
    logic walk_end;
    logic hdr_fit;
    logic hdr_alloc;
    logic grow_fits;
    logic rest_big;
    logic n_zero;
    logic first_zero;
    logic pfree;
    logic nxt_free;
    logic out_valid;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_INIT_H, S_INIT_F, S_INIT_N, S_INIT_P, S_IDLE, S_DEC,
    S_WALK_HEAD, S_WALK_HDR, S_WALK_NEXT, S_MISS, S_GROW_CHK, S_G_HDR, S_G_FTR,
    S_PUSH_RD, S_PUSH_FIRST, S_PUSH_PREV, S_PUSH_ROOT, S_PUSH_FPREV,
    S_T_RDP, S_T_RDN, S_T_N,
    S_SP_RH, S_SP_RF, S_SP_RP, S_SP_RN, S_SP_PN, S_SP_NP, S_SP_BH, S_SP_BF,
    S_WH_H, S_WH_F, S_UL_PN, S_UL_NP, S_CLR_N, S_CLR_P,
    S_F_CHK, S_F_PF, S_F_TAG2, S_F_RDPREV, S_F_PREVD, S_F_NXTD,
    S_N_RDP, S_N_RDN, S_N_UL1, S_N_UL2, S_N_T, S_N_H,
    S_P_RDP, S_P_RDN, S_P_UL1, S_P_UL2, S_P_H, S_P_T,
    S_DONE
  } state_t;

endpackage

// File: rtl/efla_datapath.sv
module efla_datapath import efla_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam int unsigned WORDS = HEAP_BYTES / 4;
  localparam int unsigned IW = $clog2(WORDS);
  localparam int unsigned TW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned LIMIT = HEAP_BYTES / MIN_BLOCK_BYTES + 2;
  localparam int unsigned SW = $clog2(LIMIT + 1);
  localparam int unsigned AW = 17;
  localparam int unsigned GW = 18;

  logic [31:0] mem [WORDS];
  logic [31:0] mem_q;
  logic        mem_q_ok;
  logic [31:0] rd;

  logic          opcode;
  logic [15:0]   req;
  logic [15:0]   addr_in;
  logic [AW-1:0] asize;
  logic [GW-1:0] gsize;
  logic [TW-1:0] top;
  logic [SW-1:0] steps;
  logic [31:0]   bp, whole, rest, p, n, r, prv, nxt, tail, first, nsize, psize;
  logic          pfree;
  logic [15:0]   res;
  logic [1:0]    res_st;

  logic [31:0] base, off, maddr, wdata, rd_size;
  logic        in_range;
  logic [AW-1:0] ext;
  logic [GW-3:0] ext_words;

  assign rd = mem_q_ok ? mem_q : 32'd0;
  assign rd_size = rd & ~32'h7;

  // heap access address
  always_comb begin
    case (cmd.base)
      B_ROOT:  base = ROOT_BP;
      B_BP:    base = bp;
      B_RD:    base = rd;
      B_P:     base = p;
      B_N:     base = n;
      B_FIRST: base = first;
      B_R:     base = r;
      B_PRV:   base = prv;
      B_NXT:   base = nxt;
      B_TAIL:  base = tail;
      B_ADDR:  base = {16'd0, addr_in};
      default: base = ROOT_BP;
    endcase
    case (cmd.off)
      O_HDR:   off = -32'd12;
      O_NEXT:  off = -32'd8;
      O_PREV:  off = -32'd4;
      O_PFTR:  off = -32'd16;
      O_ZERO:  off = 32'd0;
      O_WHOLE: off = whole - 32'd16;
      O_ASIZE: off = {{(32-AW){1'b0}}, asize} - 32'd16;
      O_REST:  off = rest - 32'd16;
      default: off = 32'd0;
    endcase
    maddr = base + off;
    in_range = maddr[31:2] < 30'(WORDS);
  end

  // heap write data
  always_comb begin
    case (cmd.wsel)
      W_ZERO:    wdata = 32'd0;
      W_WHOLE:   wdata = whole;
      W_WHOLE_A: wdata = whole | 32'd1;
      W_ASIZE_A: wdata = {{(32-AW){1'b0}}, asize} | 32'd1;
      W_REST:    wdata = rest;
      W_RD:      wdata = rd;
      W_ROOT:    wdata = ROOT_BP;
      W_BP:      wdata = bp;
      W_R:       wdata = r;
      W_N:       wdata = n;
      W_P:       wdata = p;
      default:   wdata = 32'd0;
    endcase
  end

  // heap memory, one access a cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && in_range) begin
      mem[maddr[IW+1:2]] <= wdata;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[maddr[IW+1:2]];
      mem_q_ok <= in_range;
    end
  end

  // grow size: larger of request and chunk, rounded to 8 bytes
  always_comb begin
    ext = (asize > AW'(CHUNK_BYTES)) ? asize : AW'(CHUNK_BYTES);
    ext_words = (GW-2)'(ext[AW-1:2]) + (GW-2)'(ext[2]);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= TW'(INIT_TOP);
      asize <= AW'(CHUNK_BYTES);
      whole <= 32'(MIN_BLOCK_BYTES);
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          opcode <= s_tuser;
          req <= s_tdata[15:0];
          addr_in <= s_tdata[31:16];
        end
        OP_DECODE: asize <= (AW'(req) + AW'(23)) & ~AW'(7);
        OP_LD_HEAD: begin
          bp <= rd;
          steps <= '0;
        end
        OP_LD_NEXT: begin
          bp <= rd;
          steps <= steps + SW'(1);
        end
        OP_LD_WHOLE: whole <= rd_size;
        OP_CALC_EXT: gsize <= {ext_words[GW-3:0], 2'b00};
        OP_GROW_SET: begin
          bp <= 32'(top) + 32'd12;
          whole <= 32'(gsize);
          top <= top + TW'(gsize);
        end
        OP_LD_FIRST: first <= rd;
        OP_REST: begin
          rest <= whole - 32'(asize);
          r <= bp + 32'(asize);
        end
        OP_LD_P: p <= rd;
        OP_LD_N: n <= rd;
        OP_FREE_SET: begin
          bp <= {16'd0, addr_in};
          whole <= rd_size;
        end
        OP_LD_PRVNXT: begin
          prv <= bp - rd_size;
          nxt <= bp + whole;
        end
        OP_LD_PREVF: begin
          pfree <= ~rd[0];
          psize <= rd_size;
        end
        OP_LD_NEXTF: nsize <= rd_size;
        OP_TAIL_N: tail <= nxt + nsize - 32'd16;
        OP_TAIL_P: tail <= bp + whole - 32'd16;
        OP_ADD_N: whole <= whole + nsize;
        OP_ADD_P: whole <= whole + psize;
        OP_MV_PRV: bp <= prv;
        OP_RES_OK: begin
          res <= bp[15:0];
          res_st <= ST_OK;
        end
        OP_RES_ZERO: begin
          res <= 16'd0;
          res_st <= ST_ZERO;
        end
        OP_RES_FULL: begin
          res <= 16'd0;
          res_st <= ST_FULL;
        end
        OP_RES_NONE: begin
          res <= 16'd0;
          res_st <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res;
      m_tuser <= res_st;
    end
  end

  // status to the controller
  always_comb begin
    stat.op_free    = (opcode == OPC_FREE);
    stat.req_zero   = (req == 16'd0);
    stat.addr_ok    = ({16'd0, addr_in} >= FIRST_BP) && ({16'd0, addr_in} < 32'(top));
    stat.rd_zero    = (rd == 32'd0);
    stat.walk_end   = (rd_size == 32'd0) || (32'(steps) >= 32'(LIMIT));
    stat.hdr_fit    = !rd[0] && (32'(asize) <= rd_size);
    stat.hdr_alloc  = rd[0];
    stat.grow_fits  = (32'(top) + 32'(gsize)) <= 32'(HEAP_BYTES);
    stat.rest_big   = rest >= 32'(MIN_BLOCK_BYTES);
    stat.n_zero     = (n == 32'd0);
    stat.first_zero = (first == 32'd0);
    stat.pfree      = pfree;
    stat.nxt_free   = (nxt < 32'(top)) && !rd[0];
    stat.out_valid  = m_tvalid;
  end

  // failed or zero-size requests never grant an address
  a_no_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tdata == 16'd0)
    else $error("error result carries an address");

  // heap never grows past its end
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    32'(top) <= 32'(HEAP_BYTES) && 32'(top) >= INIT_TOP)
    else $error("heap top out of range");

endmodule

// File: rtl/efla_ctrl.sv
module efla_ctrl import efla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   init, init_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_H;
      init <= 1'b1;
    end else begin
      state <= state_next;
      init <= init_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    init_next = init;
    cmd = '{mem_rd: 1'b0, mem_wr: 1'b0, base: B_ROOT, off: O_ZERO, wsel: W_ZERO,
            op: OP_NONE, out_load: 1'b0};
    case (state)
      // root sentinel
      S_INIT_H: begin
        cmd.mem_wr = 1'b1; cmd.off = O_HDR; cmd.wsel = W_WHOLE_A;
        state_next = S_INIT_F;
      end
      S_INIT_F: begin
        cmd.mem_wr = 1'b1; cmd.off = O_WHOLE; cmd.wsel = W_WHOLE_A;
        state_next = S_INIT_N;
      end
      S_INIT_N: begin
        cmd.mem_wr = 1'b1; cmd.off = O_NEXT;
        state_next = S_INIT_P;
      end
      S_INIT_P: begin
        cmd.mem_wr = 1'b1; cmd.off = O_PREV;
        state_next = S_MISS;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LATCH;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op_free) begin
          if (stat.addr_ok) begin
            cmd.mem_rd = 1'b1; cmd.base = B_ADDR; cmd.off = O_HDR;
            state_next = S_F_CHK;
          end else begin
            cmd.op = OP_RES_NONE;
            state_next = S_DONE;
          end
        end else if (stat.req_zero) begin
          cmd.op = OP_RES_ZERO;
          state_next = S_DONE;
        end else begin
          cmd.op = OP_DECODE;
          cmd.mem_rd = 1'b1; cmd.off = O_NEXT;
          state_next = S_WALK_HEAD;
        end
      end
      // first-fit walk, one header read and one link read a node
      S_WALK_HEAD, S_WALK_NEXT: begin
        cmd.op = (state == S_WALK_HEAD) ? OP_LD_HEAD : OP_LD_NEXT;
        if (stat.rd_zero) begin
          state_next = S_MISS;
        end else begin
          cmd.mem_rd = 1'b1; cmd.base = B_RD; cmd.off = O_HDR;
          state_next = S_WALK_HDR;
        end
      end
      S_WALK_HDR: begin
        if (stat.walk_end) begin
          state_next = S_MISS;
        end else if (stat.hdr_fit) begin
          cmd.op = OP_LD_WHOLE;
          state_next = S_T_RDP;
        end else begin
          cmd.mem_rd = 1'b1; cmd.base = B_BP; cmd.off = O_NEXT;
          state_next = S_WALK_NEXT;
        end
      end
      // heap growth
      S_MISS: begin
        cmd.op = OP_CALC_EXT;
        state_next = S_GROW_CHK;
      end
      S_GROW_CHK: begin
        if (stat.grow_fits) begin
          cmd.op = OP_GROW_SET;
          state_next = S_G_HDR;
        end else if (init) begin
          init_next = 1'b0;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_RES_FULL;
          state_next = S_DONE;
        end
      end
      S_G_HDR: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_HDR; cmd.wsel = W_WHOLE;
        state_next = S_G_FTR;
      end
      S_G_FTR: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_WHOLE; cmd.wsel = W_WHOLE;
        state_next = S_PUSH_RD;
      end
      // push bp at the list head
      S_PUSH_RD: begin
        cmd.mem_rd = 1'b1; cmd.off = O_NEXT;
        state_next = S_PUSH_FIRST;
      end
      S_PUSH_FIRST: begin
        cmd.op = OP_LD_FIRST;
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_NEXT; cmd.wsel = W_RD;
        state_next = S_PUSH_PREV;
      end
      S_PUSH_PREV: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_PREV; cmd.wsel = W_ROOT;
        state_next = S_PUSH_ROOT;
      end
      S_PUSH_ROOT: begin
        cmd.mem_wr = 1'b1; cmd.off = O_NEXT; cmd.wsel = W_BP;
        state_next = S_PUSH_FPREV;
      end
      S_PUSH_FPREV: begin
        cmd.mem_wr = !stat.first_zero;
        cmd.base = B_FIRST; cmd.off = O_PREV; cmd.wsel = W_BP;
        if (init) begin
          init_next = 1'b0;
          state_next = S_IDLE;
        end else if (stat.op_free) begin
          cmd.op = OP_RES_NONE;
          state_next = S_DONE;
        end else begin
          state_next = S_T_RDP;
        end
      end
      // take the block: fetch its links
      S_T_RDP: begin
        cmd.op = OP_REST;
        cmd.mem_rd = 1'b1; cmd.base = B_BP; cmd.off = O_PREV;
        state_next = S_T_RDN;
      end
      S_T_RDN: begin
        cmd.op = OP_LD_P;
        cmd.mem_rd = 1'b1; cmd.base = B_BP; cmd.off = O_NEXT;
        state_next = S_T_N;
      end
      S_T_N: begin
        cmd.op = OP_LD_N;
        state_next = stat.rest_big ? S_SP_RH : S_WH_H;
      end
      // split off the remainder
      S_SP_RH: begin
        cmd.mem_wr = 1'b1; cmd.base = B_R; cmd.off = O_HDR; cmd.wsel = W_REST;
        state_next = S_SP_RF;
      end
      S_SP_RF: begin
        cmd.mem_wr = 1'b1; cmd.base = B_R; cmd.off = O_REST; cmd.wsel = W_REST;
        state_next = S_SP_RP;
      end
      S_SP_RP: begin
        cmd.mem_wr = 1'b1; cmd.base = B_R; cmd.off = O_PREV; cmd.wsel = W_P;
        state_next = S_SP_RN;
      end
      S_SP_RN: begin
        cmd.mem_wr = 1'b1; cmd.base = B_R; cmd.off = O_NEXT; cmd.wsel = W_N;
        state_next = S_SP_PN;
      end
      S_SP_PN: begin
        cmd.mem_wr = 1'b1; cmd.base = B_P; cmd.off = O_NEXT; cmd.wsel = W_R;
        state_next = S_SP_NP;
      end
      S_SP_NP: begin
        cmd.mem_wr = !stat.n_zero; cmd.base = B_N; cmd.off = O_PREV; cmd.wsel = W_R;
        state_next = S_SP_BH;
      end
      S_SP_BH: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_HDR; cmd.wsel = W_ASIZE_A;
        state_next = S_SP_BF;
      end
      S_SP_BF: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_ASIZE; cmd.wsel = W_ASIZE_A;
        state_next = S_CLR_N;
      end
      // whole block taken
      S_WH_H: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_HDR; cmd.wsel = W_WHOLE_A;
        state_next = S_WH_F;
      end
      S_WH_F: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_WHOLE; cmd.wsel = W_WHOLE_A;
        state_next = S_UL_PN;
      end
      S_UL_PN: begin
        cmd.mem_wr = 1'b1; cmd.base = B_P; cmd.off = O_NEXT; cmd.wsel = W_N;
        state_next = S_UL_NP;
      end
      S_UL_NP: begin
        cmd.mem_wr = !stat.n_zero; cmd.base = B_N; cmd.off = O_PREV; cmd.wsel = W_P;
        state_next = S_CLR_N;
      end
      S_CLR_N: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_NEXT;
        state_next = S_CLR_P;
      end
      S_CLR_P: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_PREV;
        cmd.op = OP_RES_OK;
        state_next = S_DONE;
      end
      // free: check and retag
      S_F_CHK: begin
        if (stat.hdr_alloc) begin
          cmd.op = OP_FREE_SET;
          cmd.mem_rd = 1'b1; cmd.base = B_ADDR; cmd.off = O_PFTR;
          state_next = S_F_PF;
        end else begin
          cmd.op = OP_RES_NONE;
          state_next = S_DONE;
        end
      end
      S_F_PF: begin
        cmd.op = OP_LD_PRVNXT;
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_HDR; cmd.wsel = W_WHOLE;
        state_next = S_F_TAG2;
      end
      S_F_TAG2: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_WHOLE; cmd.wsel = W_WHOLE;
        state_next = S_F_RDPREV;
      end
      S_F_RDPREV: begin
        cmd.mem_rd = 1'b1; cmd.base = B_PRV; cmd.off = O_HDR;
        state_next = S_F_PREVD;
      end
      S_F_PREVD: begin
        cmd.op = OP_LD_PREVF;
        cmd.mem_rd = 1'b1; cmd.base = B_NXT; cmd.off = O_HDR;
        state_next = S_F_NXTD;
      end
      S_F_NXTD: begin
        cmd.op = OP_LD_NEXTF;
        if (stat.nxt_free) begin
          state_next = S_N_RDP;
        end else if (stat.pfree) begin
          state_next = S_P_RDP;
        end else begin
          state_next = S_PUSH_RD;
        end
      end
      // merge with the following block
      S_N_RDP: begin
        cmd.op = OP_TAIL_N;
        cmd.mem_rd = 1'b1; cmd.base = B_NXT; cmd.off = O_PREV;
        state_next = S_N_RDN;
      end
      S_N_RDN: begin
        cmd.op = OP_LD_P;
        cmd.mem_rd = 1'b1; cmd.base = B_NXT; cmd.off = O_NEXT;
        state_next = S_N_UL1;
      end
      S_N_UL1: begin
        cmd.op = OP_LD_N;
        cmd.mem_wr = 1'b1; cmd.base = B_P; cmd.off = O_NEXT; cmd.wsel = W_RD;
        state_next = S_N_UL2;
      end
      S_N_UL2: begin
        cmd.op = OP_ADD_N;
        cmd.mem_wr = !stat.n_zero; cmd.base = B_N; cmd.off = O_PREV; cmd.wsel = W_P;
        state_next = S_N_T;
      end
      S_N_T: begin
        cmd.mem_wr = 1'b1; cmd.base = B_TAIL; cmd.wsel = W_WHOLE;
        state_next = S_N_H;
      end
      S_N_H: begin
        cmd.mem_wr = 1'b1; cmd.base = B_BP; cmd.off = O_HDR; cmd.wsel = W_WHOLE;
        state_next = stat.pfree ? S_P_RDP : S_PUSH_RD;
      end
      // merge with the preceding block
      S_P_RDP: begin
        cmd.op = OP_TAIL_P;
        cmd.mem_rd = 1'b1; cmd.base = B_PRV; cmd.off = O_PREV;
        state_next = S_P_RDN;
      end
      S_P_RDN: begin
        cmd.op = OP_LD_P;
        cmd.mem_rd = 1'b1; cmd.base = B_PRV; cmd.off = O_NEXT;
        state_next = S_P_UL1;
      end
      S_P_UL1: begin
        cmd.op = OP_LD_N;
        cmd.mem_wr = 1'b1; cmd.base = B_P; cmd.off = O_NEXT; cmd.wsel = W_RD;
        state_next = S_P_UL2;
      end
      S_P_UL2: begin
        cmd.op = OP_ADD_P;
        cmd.mem_wr = !stat.n_zero; cmd.base = B_N; cmd.off = O_PREV; cmd.wsel = W_P;
        state_next = S_P_H;
      end
      S_P_H: begin
        cmd.mem_wr = 1'b1; cmd.base = B_PRV; cmd.off = O_HDR; cmd.wsel = W_WHOLE;
        state_next = S_P_T;
      end
      S_P_T: begin
        cmd.op = OP_MV_PRV;
        cmd.mem_wr = 1'b1; cmd.base = B_TAIL; cmd.wsel = W_WHOLE;
        state_next = S_PUSH_RD;
      end
      // hand the word to the output register
      S_DONE: begin
        if (!stat.out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // single-port heap: never read and write together
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("heap read and write in one cycle");

  // every result load returns to idle
  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE)
    else $error("result load did not end the item");

  // no item taken before the heap is built
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init |-> !s_tready)
    else $error("item accepted during heap build");

endmodule

// File: rtl/explicit_free_list_allocator.sv
// Heap allocator with boundary tags and an explicit LIFO free list, first fit.
// The heap lives in one single-port word memory inside the block; every step
// makes at most one access to it, so timing follows list and merge work. After
// reset the block builds the root sentinel and the first chunk before it
// takes a word. An allocate walks the free list first fit and takes the first
// node that fits, whole or split; a miss grows the heap after the walk. A free
// retags the block, merges it with each free neighbour and pushes it at the
// list head. Zero-size and rejected requests answer without touching the list.
// One item is in work at a time; the result sits in an output register, so
// the next item can be taken while it waits.
module explicit_free_list_allocator import efla_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size, block_addr
  input  logic [0:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // result_addr
  output logic [1:0]  m_axis_tuser   // status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  efla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tready (m_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  efla_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser[0]),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready)
  );

endmodule
